// ===== hw/rtl/rgr_pkg.sv =====
// ---------------------------------------------------------------------------
// rgr_pkg: shared types and constants of the rotated glyph/rect rasterizer
// frame geometry, command codes, glyph font and controller/datapath structs
// ---------------------------------------------------------------------------
package rgr_pkg;

   localparam int FB_WIDTH    = 792;
   localparam int FB_HEIGHT   = 528;
   localparam int ROW_BYTES   = FB_WIDTH / 8;
   localparam int FB_BYTES    = ROW_BYTES * FB_HEIGHT;
   localparam int ADDR_W      = $clog2(FB_BYTES);
   localparam int PX_W        = $clog2(FB_WIDTH + 1);
   localparam int PY_W        = $clog2(FB_HEIGHT + 1);
   localparam int COL_W       = PX_W - 3;
   localparam int COORD_W     = 14;
   localparam int GLYPH_COUNT = 20;
   localparam int GIDX_W      = $clog2(GLYPH_COUNT);

   localparam logic signed [COORD_W-1:0] X_LIMIT = COORD_W'(FB_HEIGHT);
   localparam logic signed [COORD_W-1:0] Y_LIMIT = COORD_W'(FB_WIDTH);

   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_FILL  = 2'd1,
      ACT_GLYPH = 2'd2,
      ACT_READ  = 2'd3
   } action_type;

   typedef struct packed {
      action_type          action;
      logic signed [11:0]  x_pos;
      logic signed [11:0]  y_pos;
      logic [10:0]         rect_width;
      logic [10:0]         rect_height;
      logic [7:0]          char_code;
      logic [3:0]          scale_factor;
      logic                paint_black;
      logic [7:0]          fill_byte;
      logic [15:0]         read_address;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [1:0] action_echo;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic clr_step;
      logic rd_issue;
      logic dot_load;
      logic dot_adv;
      logic rect_clip;
      logic rect_init;
      logic row_start;
      logic byte_rd;
      logic byte_wr;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      action_type act;
      logic       clr_last;
      logic       glyph_hit;
      logic       dot_set;
      logic       dot_last;
      logic       empty;
      logic       col_last;
      logic       row_last;
   } dp_stat_type;

   typedef struct packed {
      logic              hit;
      logic [GIDX_W-1:0] idx;
   } glyph_sel_type;

   // 5x7 font, row 0 on top, bit 4 is the leftmost column
   localparam logic [4:0] GLYPH_ROWS [GLYPH_COUNT][7] = '{
      '{5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
      '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E},
      '{5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E},
      '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},
      '{5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F},
      '{5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
      '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F},
      '{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
      '{5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11},
      '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10},
      '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11},
      '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
      '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
      '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11},
      '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04},
      '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
      '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
      '{5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E},
      '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h06, 5'h06},
      '{5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00}
   };

   // ascii code to font row index
   function automatic glyph_sel_type glyph_lookup(input logic [7:0] code);
      glyph_sel_type sel;
      sel.hit = 1'b1;
      sel.idx = '0;
      case (code)
         8'h41: sel.idx = GIDX_W'(0);   // A
         8'h42: sel.idx = GIDX_W'(1);   // B
         8'h44: sel.idx = GIDX_W'(2);   // D
         8'h45: sel.idx = GIDX_W'(3);   // E
         8'h47: sel.idx = GIDX_W'(4);   // G
         8'h48: sel.idx = GIDX_W'(5);   // H
         8'h49: sel.idx = GIDX_W'(6);   // I
         8'h4C: sel.idx = GIDX_W'(7);   // L
         8'h4D: sel.idx = GIDX_W'(8);   // M
         8'h50: sel.idx = GIDX_W'(9);   // P
         8'h52: sel.idx = GIDX_W'(10);  // R
         8'h54: sel.idx = GIDX_W'(11);  // T
         8'h55: sel.idx = GIDX_W'(12);  // U
         8'h58: sel.idx = GIDX_W'(13);  // X
         8'h59: sel.idx = GIDX_W'(14);  // Y
         8'h30: sel.idx = GIDX_W'(15);  // 0
         8'h31: sel.idx = GIDX_W'(16);  // 1
         8'h33: sel.idx = GIDX_W'(17);  // 3
         8'h2E: sel.idx = GIDX_W'(18);  // period
         8'h2D: sel.idx = GIDX_W'(19);  // minus
         default: sel.hit = 1'b0;
      endcase
      return sel;
   endfunction

endpackage

// ===== hw/rtl/rgr_channels.sv =====
// ---------------------------------------------------------------------------
// rgr channels: request and response valid/ready interfaces
// payload fields travel next to the handshake pair
// ---------------------------------------------------------------------------
interface rgr_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic signed [11:0] x_pos;
   logic signed [11:0] y_pos;
   logic [10:0]        rect_width;
   logic [10:0]        rect_height;
   logic [7:0]         char_code;
   logic [3:0]         scale_factor;
   logic               paint_black;
   logic [7:0]         fill_byte;
   logic [15:0]        read_address;

   modport source (output valid, action, x_pos, y_pos, rect_width, rect_height,
                   char_code, scale_factor, paint_black, fill_byte, read_address,
                   input ready);
   modport sink (input valid, action, x_pos, y_pos, rect_width, rect_height,
                 char_code, scale_factor, paint_black, fill_byte, read_address,
                 output ready);
endinterface

interface rgr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic [1:0] action_echo;

   modport source (output valid, read_data, action_echo, input ready);
   modport sink (input valid, read_data, action_echo, output ready);
endinterface

// ===== hw/rtl/rgr_datapath.sv =====
// ---------------------------------------------------------------------------
// rgr_datapath: framebuffer memory, rectangle clipper and byte walker
// performs one step per command bit from the controller
// ---------------------------------------------------------------------------
module rgr_datapath (
   input  logic                 clock,
   input  rgr_pkg::req_type     req,
   input  rgr_pkg::dp_cmd_type  cmd,
   output rgr_pkg::dp_stat_type stat,
   output rgr_pkg::rsp_type     rsp
);

   localparam int AW  = rgr_pkg::ADDR_W;
   localparam int CW  = rgr_pkg::COORD_W;
   localparam int PXW = rgr_pkg::PX_W;
   localparam int PYW = rgr_pkg::PY_W;
   localparam int COW = rgr_pkg::COL_W;

   logic [7:0] mem [rgr_pkg::FB_BYTES];

   rgr_pkg::action_type       act_ff;
   logic [7:0]                fill_ff;
   logic [15:0]               addr_ff;
   logic signed [11:0]        ox_ff;
   logic signed [11:0]        oy_ff;
   logic [3:0]                scale_ff;
   rgr_pkg::glyph_sel_type    gsel_ff;
   logic [2:0]                dot_row_ff;
   logic [2:0]                dot_col_ff;

   logic signed [CW-1:0]      rx_ff;
   logic signed [CW-1:0]      ry_ff;
   logic [10:0]               rw_ff;
   logic [10:0]               rh_ff;
   logic                      black_ff;

   logic [PYW-1:0]            x_lo_ff;
   logic [PYW-1:0]            x_hi_ff;
   logic [PXW-1:0]            y_lo_ff;
   logic [PXW-1:0]            y_hi_ff;
   logic                      empty_ff;

   logic [PYW-1:0]            py_ff;
   logic [AW-1:0]             row_base_ff;
   logic [COW-1:0]            col_ff;
   logic [AW-1:0]             clr_ff;
   logic [7:0]                rd_ff;
   rgr_pkg::rsp_type          rsp_ff;

   logic signed [CW-1:0]      x_end_in;
   logic signed [CW-1:0]      y_end_in;
   logic signed [CW-1:0]      x_lo_in;
   logic signed [CW-1:0]      x_hi_in;
   logic signed [CW-1:0]      y_lo_in;
   logic signed [CW-1:0]      y_hi_in;
   logic [6:0]                col_off;
   logic [6:0]                row_off;
   logic [PXW-1:0]            y_hi_m1;
   logic [COW-1:0]            col_end;
   logic [PYW-1:0]            py_end;
   logic [AW:0]               byte_addr;
   logic                      byte_ok;
   logic                      read_ok;
   logic [7:0]                mask;
   logic [7:0]                wr_byte;
   logic [4:0]                glyph_bits;

   // clip against the logical portrait area
   assign x_end_in = rx_ff + $signed(CW'(rw_ff));
   assign y_end_in = ry_ff + $signed(CW'(rh_ff));
   assign x_lo_in  = (rx_ff < 0) ? '0 : rx_ff;
   assign y_lo_in  = (ry_ff < 0) ? '0 : ry_ff;
   assign x_hi_in  = (x_end_in > rgr_pkg::X_LIMIT) ? rgr_pkg::X_LIMIT : x_end_in;
   assign y_hi_in  = (y_end_in > rgr_pkg::Y_LIMIT) ? rgr_pkg::Y_LIMIT : y_end_in;

   assign col_off  = 7'(dot_col_ff) * 7'(scale_ff);
   assign row_off  = 7'(dot_row_ff) * 7'(scale_ff);

   assign y_hi_m1   = y_hi_ff - PXW'(1);
   assign col_end   = y_hi_m1[PXW-1:3];
   assign py_end    = PYW'(rgr_pkg::FB_HEIGHT - 1) - x_lo_ff;
   assign byte_addr = (AW+1)'(row_base_ff) + (AW+1)'(col_ff);
   assign byte_ok   = byte_addr < (AW+1)'(rgr_pkg::FB_BYTES);
   assign read_ok   = addr_ff < 16'(rgr_pkg::FB_BYTES);

   always_comb begin
      for (int j = 0; j < 8; j++) begin
         mask[7-j] = ({col_ff, 3'(j)} >= y_lo_ff) && ({col_ff, 3'(j)} < y_hi_ff);
      end
   end

   assign wr_byte    = black_ff ? (rd_ff & ~mask) : (rd_ff | mask);
   assign glyph_bits = rgr_pkg::GLYPH_ROWS[gsel_ff.idx][dot_row_ff];

   always_comb begin
      stat.act       = act_ff;
      stat.clr_last  = clr_ff == AW'(rgr_pkg::FB_BYTES - 1);
      stat.glyph_hit = gsel_ff.hit;
      stat.dot_set   = glyph_bits[3'd4 - dot_col_ff];
      stat.dot_last  = (dot_row_ff == 3'd6) && (dot_col_ff == 3'd4);
      stat.empty     = empty_ff;
      stat.col_last  = col_ff == col_end;
      stat.row_last  = py_ff == py_end;
   end

   assign rsp = rsp_ff;

   // framebuffer: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         mem[clr_ff] <= fill_ff;
      end else if (cmd.byte_wr && byte_ok) begin
         mem[byte_addr[AW-1:0]] <= wr_byte;
      end
      if (cmd.rd_issue && read_ok) begin
         rd_ff <= mem[addr_ff[AW-1:0]];
      end else if (cmd.byte_rd && byte_ok) begin
         rd_ff <= mem[byte_addr[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff     <= req.action;
         fill_ff    <= req.fill_byte;
         addr_ff    <= req.read_address;
         ox_ff      <= req.x_pos;
         oy_ff      <= req.y_pos;
         scale_ff   <= req.scale_factor;
         gsel_ff    <= rgr_pkg::glyph_lookup(req.char_code);
         dot_row_ff <= '0;
         dot_col_ff <= '0;
         clr_ff     <= '0;
         rx_ff      <= CW'(req.x_pos);
         ry_ff      <= CW'(req.y_pos);
         rw_ff      <= req.rect_width;
         rh_ff      <= req.rect_height;
         black_ff   <= req.paint_black;
      end
      if (cmd.clr_step) begin
         clr_ff <= clr_ff + AW'(1);
      end
      if (cmd.dot_load) begin
         rx_ff    <= CW'(ox_ff) + $signed(CW'(col_off));
         ry_ff    <= CW'(oy_ff) + $signed(CW'(row_off));
         rw_ff    <= 11'(scale_ff);
         rh_ff    <= 11'(scale_ff);
         black_ff <= 1'b1;
      end
      if (cmd.dot_adv) begin
         if (dot_col_ff == 3'd4) begin
            dot_col_ff <= '0;
            dot_row_ff <= dot_row_ff + 3'd1;
         end else begin
            dot_col_ff <= dot_col_ff + 3'd1;
         end
      end
      if (cmd.rect_clip) begin
         empty_ff <= (x_hi_in <= x_lo_in) || (y_hi_in <= y_lo_in);
         x_lo_ff  <= x_lo_in[PYW-1:0];
         x_hi_ff  <= x_hi_in[PYW-1:0];
         y_lo_ff  <= y_lo_in[PXW-1:0];
         y_hi_ff  <= y_hi_in[PXW-1:0];
      end
      if (cmd.rect_init) begin
         py_ff <= PYW'(rgr_pkg::FB_HEIGHT) - x_hi_ff;
      end
      if (cmd.row_start) begin
         row_base_ff <= AW'(py_ff) * AW'(rgr_pkg::ROW_BYTES);
         col_ff      <= y_lo_ff[PXW-1:3];
      end
      if (cmd.byte_wr) begin
         if (col_ff == col_end) begin
            py_ff <= py_ff + PYW'(1);
         end else begin
            col_ff <= col_ff + COW'(1);
         end
      end
      if (cmd.finish) begin
         rsp_ff.read_data   <= (act_ff == rgr_pkg::ACT_READ && read_ok) ? rd_ff : 8'h00;
         rsp_ff.action_echo <= act_ff;
      end
   end

endmodule

// ===== hw/rtl/rgr_ctrl.sv =====
// ---------------------------------------------------------------------------
// rgr_ctrl: command sequencer of the rasterizer
// walks clear, read, rectangle and glyph commands and owns the handshakes
// ---------------------------------------------------------------------------
module rgr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rgr_pkg::dp_cmd_type  cmd,
   input  rgr_pkg::dp_stat_type stat
);

   typedef enum logic [11:0] {
      ST_IDLE      = 12'b0000_0000_0001,
      ST_DISPATCH  = 12'b0000_0000_0010,
      ST_CLEAR     = 12'b0000_0000_0100,
      ST_READ      = 12'b0000_0000_1000,
      ST_GLYPH     = 12'b0000_0001_0000,
      ST_GLYPH_ADV = 12'b0000_0010_0000,
      ST_CLIP      = 12'b0000_0100_0000,
      ST_INIT      = 12'b0000_1000_0000,
      ST_ROW       = 12'b0001_0000_0000,
      ST_BYTE_RD   = 12'b0010_0000_0000,
      ST_BYTE_WR   = 12'b0100_0000_0000,
      ST_FINISH    = 12'b1000_0000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;
   state_type rect_done;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rect_done = (stat.act == rgr_pkg::ACT_GLYPH) ? ST_GLYPH_ADV : ST_FINISH;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (stat.act)
               rgr_pkg::ACT_CLEAR: state_in = ST_CLEAR;
               rgr_pkg::ACT_FILL:  state_in = ST_CLIP;
               rgr_pkg::ACT_GLYPH: state_in = ST_GLYPH;
               default:            state_in = ST_READ;
            endcase
         end
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_FINISH;
         end
         ST_GLYPH: begin
            if (!stat.glyph_hit) begin
               state_in = ST_FINISH;
            end else if (stat.dot_set) begin
               cmd.dot_load = 1'b1;
               state_in     = ST_CLIP;
            end else begin
               state_in = ST_GLYPH_ADV;
            end
         end
         ST_GLYPH_ADV: begin
            if (stat.dot_last) begin
               state_in = ST_FINISH;
            end else begin
               cmd.dot_adv = 1'b1;
               state_in    = ST_GLYPH;
            end
         end
         ST_CLIP: begin
            cmd.rect_clip = 1'b1;
            state_in      = ST_INIT;
         end
         ST_INIT: begin
            if (stat.empty) begin
               state_in = rect_done;
            end else begin
               cmd.rect_init = 1'b1;
               state_in      = ST_ROW;
            end
         end
         ST_ROW: begin
            cmd.row_start = 1'b1;
            state_in      = ST_BYTE_RD;
         end
         ST_BYTE_RD: begin
            cmd.byte_rd = 1'b1;
            state_in    = ST_BYTE_WR;
         end
         ST_BYTE_WR: begin
            cmd.byte_wr = 1'b1;
            if (!stat.col_last) begin
               state_in = ST_BYTE_RD;
            end else if (stat.row_last) begin
               state_in = rect_done;
            end else begin
               state_in = ST_ROW;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_wr_after_rd: assert property (@(posedge clock) disable iff (reset)
      cmd.byte_wr |-> $past(cmd.byte_rd))
      else $error("byte write without preceding read");
   a_clear_run: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_step && !stat.clr_last |=> cmd.clr_step)
      else $error("clear sweep broke off early");
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.finish))
      else $error("response raised without a finished command");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted request did not start work");
`endif

endmodule

// ===== hw/rtl/rotated_glyph_rect_rasterizer.sv =====
// ---------------------------------------------------------------------------
// rotated_glyph_rect_rasterizer: 1 bpp landscape framebuffer drawing engine
// clears, fills rotated rectangles, draws 5x7 glyphs and reads bytes back
// ---------------------------------------------------------------------------
//
//   channel   | dir | handshake     | carries
//   ----------+-----+---------------+-----------------------------------------
//   req_chan  | in  | valid/ready   | one command: action, coords, size, glyph
//   rsp_chan  | out | valid/ready   | read_data and action_echo, one per request
//
// sequence: a fill clips, then walks its rows byte by byte; a glyph visits each
//   dot and fills one scale-sized rectangle per set dot (an unknown code draws
//   nothing); the framebuffer's single read-modify-write port sets the pace,
//   each touched byte being read and then written back
// reset: synchronous, clears controller state only; framebuffer contents are
//   undefined until the first clear
// stalls: the response sits in an output register; a new request is taken
//   while it waits, and only the next completion waits for it to drain
//
module rotated_glyph_rect_rasterizer (
   input logic       clock,
   input logic       reset,
   rgr_req_if.sink   req_chan,
   rgr_rsp_if.source rsp_chan
);

   rgr_pkg::req_type     req_pl;
   rgr_pkg::rsp_type     rsp_pl;
   rgr_pkg::dp_cmd_type  cmd;
   rgr_pkg::dp_stat_type stat;

   // gather request payload into one bundle for the datapath
   always_comb begin
      req_pl.action       = rgr_pkg::action_type'(req_chan.action);
      req_pl.x_pos        = req_chan.x_pos;
      req_pl.y_pos        = req_chan.y_pos;
      req_pl.rect_width   = req_chan.rect_width;
      req_pl.rect_height  = req_chan.rect_height;
      req_pl.char_code    = req_chan.char_code;
      req_pl.scale_factor = req_chan.scale_factor;
      req_pl.paint_black  = req_chan.paint_black;
      req_pl.fill_byte    = req_chan.fill_byte;
      req_pl.read_address = req_chan.read_address;
   end

   // response payload straight from the datapath output register
   assign rsp_chan.read_data   = rsp_pl.read_data;
   assign rsp_chan.action_echo = rsp_pl.action_echo;

   // sequencer: owns both handshakes and steps the datapath
   rgr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // memory, clipper and byte walker
   rgr_datapath u_datapath (
      .clock (clock),
      .req   (req_pl),
      .cmd   (cmd),
      .stat  (stat),
      .rsp   (rsp_pl)
   );

endmodule
